FILE: sv/ams_pkg.sv
// Shared types, codes and width helpers for the adjacency matrix store.
// Used by ams_cell and adjacency_matrix_store; depends on nothing else.
package ams_pkg;

  // Default store size and fixed field widths.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int FUNC_W = 3;
  localparam int VTX_W  = 6;
  localparam int NC_W   = 7;
  localparam int STS_W  = 2;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FN_ADD_EDGE   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEL_EDGE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ADD_VERTEX = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_VERTEX = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd5;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  // Operation broadcast to every row cell.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SET,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     bit_val;
    logic     directed;
  } cell_cmd_t;

  // Request word.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VTX_W-1:0]  vertex_a;
    logic [VTX_W-1:0]  vertex_b;
    logic [NC_W-1:0]   new_count;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [STS_W-1:0] status;
    logic             edge_present;
    logic [NC_W-1:0]  vertex_count;
  } out_word_t;

  // Width that holds vertex indices, counts and the store size for comparison.
  function automatic int key_width(input int max_v);
    int cw;
    cw = $clog2(max_v + 1);
    return (cw > NC_W) ? cw : NC_W;
  endfunction

endpackage

FILE: sv/ams_cell.sv
// One row cell of the adjacency matrix: holds one matrix row and one stage
// of the query probe chain. Depends on ams_pkg.
module ams_cell #(
  parameter int MAX_VERTICES = ams_pkg::MAX_VERTICES_DEF,
  parameter int IDX = 0,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int KW = ams_pkg::key_width(MAX_VERTICES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ams_pkg::cell_cmd_t      cmd_i,
  input  logic [KW-1:0]           a_i,
  input  logic [KW-1:0]           b_i,
  input  logic [MAX_VERTICES-1:0] row_below_i,
  output logic [MAX_VERTICES-1:0] row_o,
  input  logic                    hit_i,
  output logic                    hit_o
);
  import ams_pkg::*;

  logic [MAX_VERTICES-1:0] row_r, row_nxt;
  logic [MAX_VERTICES-1:0] keep_lo, src_row;
  logic                    hit_r, hit_nxt;
  logic                    a_hit, b_hit, b_ok;

  // Row update and probe stage.
  always_comb begin
    a_hit = (a_i == KW'(IDX));
    b_hit = (b_i == KW'(IDX));
    b_ok  = (b_i < KW'(MAX_VERTICES));
    // Columns below the deleted vertex stay put; the rest move left by one.
    for (int c = 0; c < MAX_VERTICES; c++) begin
      keep_lo[c] = (KW'(c) < a_i);
    end
    // Rows at or after the deleted vertex take the row below them.
    src_row = (KW'(IDX) >= a_i) ? row_below_i : row_r;
    row_nxt = row_r;
    case (cmd_i.op)
      CELL_SET: begin
        if (a_hit) begin
          row_nxt[b_i[VW-1:0]] = cmd_i.bit_val;
        end
        if (b_hit && !cmd_i.directed) begin
          row_nxt[a_i[VW-1:0]] = cmd_i.bit_val;
        end
      end
      CELL_SHIFT: row_nxt = (src_row & keep_lo) | ((src_row >> 1) & ~keep_lo);
      CELL_CLEAR: row_nxt = '0;
      default:    row_nxt = row_r;
    endcase
    hit_nxt = hit_i | (a_hit && b_ok && row_r[b_i[VW-1:0]]);
  end

  // Row storage and probe register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      hit_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      hit_r <= hit_nxt;
    end
  end

  assign row_o = row_r;
  assign hit_o = hit_r;

endmodule

FILE: sv/adjacency_matrix_store.sv
// Adjacency matrix store: a chain of MAX_VERTICES row cells plus the request
// controller. An accepted request is applied to the row cells in the execute
// state, then the scan state waits for the query bit to cross the whole chain;
// busy stays high until out_strobe, so one request is taken at a time.
// Reset clears the whole matrix, the vertex count and the directed flag dir_r at once.
// The receiver cannot stall; each result word is shown for one cycle.
module adjacency_matrix_store #(
  parameter int MAX_VERTICES = ams_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ams_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output ams_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import ams_pkg::*;

  localparam int KW   = key_width(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  state_t                state_r;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic [CNTW-1:0]       scan_cnt_r;
  logic                  dir_r;
  logic [KW-1:0]         a_r, b_r;
  logic [STS_W-1:0]      status_r, status_nxt;
  cell_op_t              cell_op_r, op_nxt;
  logic                  bit_r, bit_nxt;
  logic                  out_strobe_r;
  out_word_t             out_word_r;
  logic [KW-1:0]         a_k, b_k, nc_k, cnt_k;
  logic                  edge_ok;
  cell_cmd_t             cmd;
  logic [MAX_VERTICES-1:0] rows_w [MAX_VERTICES+1];
  logic                  hits_w [MAX_VERTICES+1];

  // Request decode against the current vertex count.
  always_comb begin
    a_k        = KW'(in_word.vertex_a);
    b_k        = KW'(in_word.vertex_b);
    nc_k       = KW'(in_word.new_count);
    cnt_k      = KW'(count_r);
    edge_ok    = (a_k < cnt_k) && (b_k < cnt_k);
    status_nxt = STS_DONE;
    count_nxt  = count_r;
    op_nxt     = CELL_HOLD;
    bit_nxt    = 1'b0;
    case (in_word.func)
      FN_ADD_EDGE, FN_DEL_EDGE: begin
        if (edge_ok) begin
          op_nxt  = CELL_SET;
          bit_nxt = (in_word.func == FN_ADD_EDGE);
        end else begin
          status_nxt = STS_RANGE;
        end
      end
      FN_ADD_VERTEX: begin
        if (cnt_k >= KW'(MAX_VERTICES)) begin
          status_nxt = STS_FULL;
        end else begin
          count_nxt = count_r + CNTW'(1);
        end
      end
      FN_DEL_VERTEX: begin
        if (a_k < cnt_k) begin
          op_nxt    = CELL_SHIFT;
          count_nxt = count_r - CNTW'(1);
        end else begin
          status_nxt = STS_RANGE;
        end
      end
      FN_QUERY: begin
        if (!edge_ok) begin
          status_nxt = STS_RANGE;
        end
      end
      FN_CLEAR: begin
        op_nxt    = CELL_CLEAR;
        count_nxt = (nc_k > KW'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES) : CNTW'(nc_k);
      end
      default: status_nxt = STS_DONE;
    endcase
  end

  // Controller state, request registers and the result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      scan_cnt_r   <= '0;
      dir_r        <= 1'b0;
      cell_op_r    <= CELL_HOLD;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        dir_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            a_r       <= a_k;
            b_r       <= b_k;
            status_r  <= status_nxt;
            count_r   <= count_nxt;
            cell_op_r <= op_nxt;
            bit_r     <= bit_nxt;
            state_r   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cell_op_r  <= CELL_HOLD;
          scan_cnt_r <= '0;
          state_r    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_cnt_r == CNTW'(MAX_VERTICES)) begin
            out_strobe_r            <= 1'b1;
            out_word_r.status       <= status_r;
            out_word_r.edge_present <= hits_w[MAX_VERTICES];
            out_word_r.vertex_count <= NC_W'(count_r);
            state_r                 <= ST_IDLE;
          end else begin
            scan_cnt_r <= scan_cnt_r + CNTW'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Command broadcast to the row cells; active for the execute cycle only.
  always_comb begin
    cmd.op       = cell_op_r;
    cmd.bit_val  = bit_r;
    cmd.directed = dir_r;
  end

  // Chain of row cells: rows pass up on vertex delete, the probe bit passes down.
  assign rows_w[MAX_VERTICES] = '0;
  assign hits_w[0]            = 1'b0;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    ams_cell #(
      .MAX_VERTICES(MAX_VERTICES),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd_i      (cmd),
      .a_i        (a_r),
      .b_i        (b_r),
      .row_below_i(rows_w[i+1]),
      .row_o      (rows_w[i]),
      .hit_i      (hits_w[i]),
      .hit_o      (hits_w[i+1])
    );
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // The result word appears only once the controller is ready again.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word shown while controller busy");

  // An accepted request keeps the controller busy through the execute cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == ST_EXEC))
    else $error("accepted request did not enter execute");

  // The vertex count never exceeds the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_VERTICES))
    else $error("vertex count beyond store size");

  // Cells see a matrix command only during the execute cycle.
  a_cmd_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_op_r != CELL_HOLD) |-> (state_r == ST_EXEC))
    else $error("cell command outside execute cycle");

  // The scan takes the full chain length before the result is shown.
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> $past(scan_cnt_r) == CNTW'(MAX_VERTICES))
    else $error("result shown before the probe crossed the chain");

endmodule

FILE: tb/adjacency_matrix_store_test.sv
// Self-checking testbench for adjacency_matrix_store: directed tests, then random graph traffic.
// It keeps its own bit-matrix model of the graph and checks every result word against it.
// Depends on ams_pkg and adjacency_matrix_store.
module adjacency_matrix_store_test;
  import ams_pkg::*;

  localparam int MAXV = MAX_VERTICES_DEF;
  localparam int IDLE_LIMIT = 2000;
  // The two function codes that the block leaves unused.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;
  logic      cfg_we;
  logic      cfg_wdata;

  // Graph model: edge_bits[row][col] is the edge from row to col.
  logic [MAXV-1:0] edge_bits [MAXV];
  int              live_n;
  logic            directed_q;

  out_word_t results_due[$];
  out_word_t due;
  int        errors;
  int        results_checked;
  int        words_sent;
  int        peak_count;
  int        idle_cycles;
  int        func_hits [8];
  bit        gaps_on;

  adjacency_matrix_store #(.MAX_VERTICES(MAXV)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request word to the graph model and return the result it must give.
  function automatic out_word_t apply_request(input in_word_t w);
    out_word_t r;
    int        a;
    int        b;
    int        n;
    int        i;
    int        j;
    bit        in_live;
    a = int'(w.vertex_a);
    b = int'(w.vertex_b);
    r = '0;
    r.status = STS_DONE;
    in_live = (a < live_n) && (b < live_n);
    case (w.func)
      FN_ADD_EDGE, FN_DEL_EDGE: begin
        if (in_live) begin
          edge_bits[a][b] = (w.func == FN_ADD_EDGE);
          if (!directed_q) edge_bits[b][a] = (w.func == FN_ADD_EDGE);
        end else begin
          r.status = STS_RANGE;
        end
      end
      FN_ADD_VERTEX: begin
        if (live_n >= MAXV) r.status = STS_FULL;
        else live_n++;
      end
      FN_DEL_VERTEX: begin
        if (a < live_n) begin
          n = live_n;
          // Later rows move up, later columns move left, then the last row and column clear.
          for (i = a; i + 1 < n; i++) edge_bits[i] = edge_bits[i + 1];
          for (i = 0; i < n; i++)
            for (j = a; j + 1 < n; j++) edge_bits[i][j] = edge_bits[i][j + 1];
          for (i = 0; i < n; i++) begin
            edge_bits[n - 1][i] = 1'b0;
            edge_bits[i][n - 1] = 1'b0;
          end
          live_n = n - 1;
        end else begin
          r.status = STS_RANGE;
        end
      end
      FN_QUERY: begin
        if (!in_live) r.status = STS_RANGE;
      end
      FN_CLEAR: begin
        for (i = 0; i < MAXV; i++) edge_bits[i] = '0;
        live_n = (int'(w.new_count) > MAXV) ? MAXV : int'(w.new_count);
      end
      default: begin
      end
    endcase
    if (a < MAXV && b < MAXV) r.edge_present = edge_bits[a][b];
    r.vertex_count = live_n[NC_W-1:0];
    if (live_n > peak_count) peak_count = live_n;
    return r;
  endfunction

  // Offer one word until the block takes it, record the expected result, then maybe pause.
  task automatic send_request(input in_word_t w);
    int unsigned gap;
    int unsigned pick;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    results_due.push_back(apply_request(w));
    func_hits[w.func]++;
    words_sent++;
    gap = 0;
    if (gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) gap = $urandom_range(20, 150);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [FUNC_W-1:0] f, input int a, input int b, input int nc);
    in_word_t w;
    w.func = f;
    w.vertex_a = a[VTX_W-1:0];
    w.vertex_b = b[VTX_W-1:0];
    w.new_count = nc[NC_W-1:0];
    send_request(w);
  endtask

  // Stop offering words and wait until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_directed(input logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    directed_q = v;
    @(posedge clk);
  endtask

  // Random request, mostly well formed against the current vertex count.
  function automatic in_word_t random_request();
    in_word_t    w;
    int unsigned pick;
    int unsigned sel;
    w.func = FN_QUERY;
    w.vertex_a = VTX_W'($urandom_range(0, 63));
    w.vertex_b = VTX_W'($urandom_range(0, 63));
    w.new_count = NC_W'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 28) w.func = FN_ADD_EDGE;
    else if (pick < 38) w.func = FN_DEL_EDGE;
    else if (pick < 46) w.func = FN_ADD_VERTEX;
    else if (pick < 54) w.func = FN_DEL_VERTEX;
    else if (pick < 80) w.func = FN_QUERY;
    else if (pick < 85) begin
      w.func = FN_CLEAR;
      sel = $urandom_range(0, 9);
      if (sel == 1) w.new_count = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'd63;
      else if (sel > 1) w.new_count = NC_W'($urandom_range(1, 16));
    end else if (pick < 87) begin
      w.func = ($urandom_range(0, 1) != 0) ? FN_SPARE_6 : FN_SPARE_7;
    end else begin
      // Noise: edge operations and queries with raw indices.
      sel = $urandom_range(0, 2);
      w.func = (sel == 0) ? FN_ADD_EDGE : (sel == 1) ? FN_DEL_EDGE : FN_QUERY;
    end
    if (pick < 80 && live_n != 0 && $urandom_range(0, 9) != 0) begin
      w.vertex_a = VTX_W'($urandom_range(0, live_n - 1));
      w.vertex_b = VTX_W'($urandom_range(0, live_n - 1));
    end
    return w;
  endfunction

  // Requests against an empty store, and the unused function codes.
  task automatic test_bad_requests();
    issue(FN_QUERY, 0, 0, 0);
    issue(FN_ADD_EDGE, 63, 63, 0);
    issue(FN_DEL_EDGE, 0, 0, 0);
    issue(FN_DEL_VERTEX, 0, 0, 0);
    issue(FN_SPARE_6, 63, 63, 127);
    issue(FN_SPARE_7, 0, 0, 0);
  endtask

  // Saturating clear, a full store, and deleting the highest vertex.
  task automatic test_capacity();
    issue(FN_CLEAR, 0, 0, 127);
    issue(FN_ADD_VERTEX, 0, 0, 0);
    issue(FN_CLEAR, 0, 0, 64);
    issue(FN_ADD_EDGE, 63, 0, 0);
    issue(FN_DEL_VERTEX, 63, 0, 0);
    issue(FN_CLEAR, 0, 0, 0);
    issue(FN_ADD_VERTEX, 0, 0, 0);
  endtask

  // Mirrored edges, a self loop and vertex removal in an undirected graph.
  task automatic test_undirected_edges();
    issue(FN_CLEAR, 0, 0, 4);
    issue(FN_ADD_EDGE, 0, 3, 0);
    issue(FN_QUERY, 3, 0, 0);
    issue(FN_ADD_EDGE, 2, 2, 0);
    issue(FN_ADD_EDGE, 3, 1, 0);
    issue(FN_DEL_VERTEX, 1, 0, 0);
    issue(FN_QUERY, 2, 0, 0);
    issue(FN_DEL_EDGE, 0, 2, 0);
    issue(FN_DEL_VERTEX, 2, 0, 0);
    issue(FN_DEL_VERTEX, 2, 0, 0);
  endtask

  // One-way edges once the graph is directed.
  task automatic test_directed_edges();
    set_directed(1'b1);
    issue(FN_CLEAR, 0, 0, 8);
    issue(FN_ADD_EDGE, 7, 0, 0);
    issue(FN_QUERY, 0, 7, 0);
    issue(FN_DEL_VERTEX, 0, 0, 0);
    issue(FN_QUERY, 6, 0, 0);
  endtask

  task automatic test_random_traffic(input logic directed, input bit with_gaps, input int count);
    set_directed(directed);
    gaps_on = with_gaps;
    repeat (count) send_request(random_request());
  endtask

  // Result check: each strobed word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %p", $time, out_word);
      end else begin
        due = results_due.pop_front();
        results_checked++;
        if (out_word.status !== due.status || out_word.edge_present !== due.edge_present ||
            out_word.vertex_count !== due.vertex_count) begin
          errors++;
          $display("%0t: mismatch expected status=%0d edge=%0d count=%0d",
                   $time, due.status, due.edge_present, due.vertex_count);
          $display("%0t:          actual   status=%0d edge=%0d count=%0d",
                   $time, out_word.status, out_word.edge_present, out_word.vertex_count);
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("[adjacency_matrix_store] ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    results_checked = 0;
    words_sent = 0;
    peak_count = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    live_n = 0;
    directed_q = 1'b0;
    foreach (func_hits[i]) func_hits[i] = 0;
    foreach (edge_bits[i]) edge_bits[i] = '0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bad_requests();
    test_capacity();
    test_undirected_edges();
    test_directed_edges();
    test_random_traffic(1'b0, 1'b1, 270);
    test_random_traffic(1'b1, 1'b0, 270);
    test_random_traffic(1'b0, 1'b0, 270);
    test_random_traffic(1'b1, 1'b1, 270);

    drain();
    repeat (MAXV + 8) @(posedge clk);
    if (results_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never came", $time, results_due.size());
    end
    $display("Sent %0d words, checked %0d results; peak vertex count %0d.",
             words_sent, results_checked, peak_count);
    $display("Mix: %0d edge adds, %0d edge deletes, %0d vertex adds, %0d vertex deletes, %0d %s",
             func_hits[FN_ADD_EDGE], func_hits[FN_DEL_EDGE], func_hits[FN_ADD_VERTEX],
             func_hits[FN_DEL_VERTEX], func_hits[FN_QUERY], "queries, both edge modes");
    if (errors == 0) begin
      $display("[adjacency_matrix_store] OK");
    end else begin
      $display("[adjacency_matrix_store] ERROR");
    end
    $finish;
  end

endmodule
